/* rtl/bmpw_pkg.sv */
// ----------------------------------------------------------------------------
// bmpw_pkg
// Shared types, constants and helper functions for the 24-bit BMP stream
// writer: header layout, controller states and controller/datapath structs.
// ----------------------------------------------------------------------------
package bmpw_pkg;

  // header and format constants
  localparam int unsigned HDR_LEN    = 14 + 40;
  localparam logic [5:0]  HDR_LAST   = 6'(HDR_LEN - 1);
  localparam logic [7:0]  DIB_SIZE   = 8'd40;
  localparam logic [7:0]  BITS_PIXEL = 8'd24;
  localparam logic [7:0]  CHAR_B     = 8'h42;
  localparam logic [7:0]  CHAR_M     = 8'h4D;
  localparam logic [7:0]  BYTE_MAX   = 8'hFF;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
  localparam logic [16:0] SIDE_MAX   = 17'd65536;
  localparam int unsigned CFG_W      = 17;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR_MUL,
    ST_HDR_ADD,
    ST_HDR_OUT,
    ST_DIV,
    ST_OUT_B,
    ST_OUT_G,
    ST_OUT_R,
    ST_OUT_PAD
  } state_t;

  typedef enum logic [2:0] {
    SEL_HDR,
    SEL_BLUE,
    SEL_GREEN,
    SEL_RED,
    SEL_ZERO
  } byte_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic       pos_clear;
    logic       pos_advance;
    logic       pix_load;
    logic       div_step;
    logic [1:0] div_idx;
    logic       body_calc;
    logic       total_calc;
    logic       emit;
    byte_sel_t  sel;
    logic [5:0] hdr_idx;
    logic       last;
    logic       done;
  } bmpw_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       out_free;
    logic       drop;
    logic       row_end;
    logic       img_end;
    logic [1:0] pad;
  } bmpw_sts_t;

  // clamp a side register into 1..65536
  function automatic logic [16:0] eff_side(input logic [16:0] v);
    logic [16:0] r;
    if (v == 17'd0) begin
      r = 17'd1;
    end else if (v > SIDE_MAX) begin
      r = SIDE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // one byte of the 54-byte file and info header
  function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input logic [31:0] total,
                                          input logic [31:0] body, input logic [16:0] w,
                                          input logic [16:0] h);
    logic [7:0] b;
    case (idx)
      6'd0:    b = CHAR_B;
      6'd1:    b = CHAR_M;
      6'd2:    b = total[7:0];
      6'd3:    b = total[15:8];
      6'd4:    b = total[23:16];
      6'd5:    b = total[31:24];
      6'd10:   b = 8'(HDR_LEN);
      6'd14:   b = DIB_SIZE;
      6'd18:   b = w[7:0];
      6'd19:   b = w[15:8];
      6'd20:   b = {7'd0, w[16]};
      6'd22:   b = h[7:0];
      6'd23:   b = h[15:8];
      6'd24:   b = {7'd0, h[16]};
      6'd26:   b = 8'd1;
      6'd28:   b = BITS_PIXEL;
      6'd34:   b = body[7:0];
      6'd35:   b = body[15:8];
      6'd36:   b = body[23:16];
      6'd37:   b = body[31:24];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

/* rtl/bmpw_div.sv */
// ----------------------------------------------------------------------------
// bmpw_div
// One unpremultiply lane: (c*255 + a/2) / a clamped to 255, two quotient
// bits per step, four steps; alpha 0 and 255 pass the channel through.
// ----------------------------------------------------------------------------
module bmpw_div import bmpw_pkg::*; (
  input  logic       clk,
  input  logic       load,
  input  logic       step,
  input  logic [1:0] step_idx,
  input  logic [7:0] chan,
  input  logic [7:0] alpha,
  output logic [7:0] result
);

  logic [15:0] rem;
  logic [7:0]  quo;
  logic [7:0]  divisor;
  logic [7:0]  chan_hold;
  logic        bypass;
  logic        clamp;

  logic [15:0] dividend;
  logic [2:0]  sh_hi;
  logic [2:0]  sh_lo;
  logic [15:0] sub_hi;
  logic [15:0] sub_lo;
  logic        q_hi;
  logic        q_lo;
  logic [15:0] rem_mid;
  logic [15:0] rem_end;

  // scaled dividend, c*255 as c*256 - c
  assign dividend = ({chan, 8'd0} - {8'd0, chan}) + {9'd0, alpha[7:1]};

  // two restoring steps, high bit first
  assign sh_hi   = 3'd7 - {step_idx, 1'b0};
  assign sh_lo   = sh_hi - 3'd1;
  assign sub_hi  = {8'd0, divisor} << sh_hi;
  assign q_hi    = (rem >= sub_hi);
  assign rem_mid = q_hi ? (rem - sub_hi) : rem;
  assign sub_lo  = {8'd0, divisor} << sh_lo;
  assign q_lo    = (rem_mid >= sub_lo);
  assign rem_end = q_lo ? (rem_mid - sub_lo) : rem_mid;

  always_ff @(posedge clk) begin
    if (load) begin
      rem       <= dividend;
      quo       <= 8'd0;
      divisor   <= alpha;
      chan_hold <= chan;
      bypass    <= (alpha == 8'd0) || (alpha == ALPHA_OPAQUE);
      clamp     <= (dividend >= {alpha, 8'd0});
    end else if (step) begin
      rem <= rem_end;
      quo <= {quo[5:0], q_hi, q_lo};
    end
  end

  // quotient of 256 or more saturates
  assign result = bypass ? chan_hold : (clamp ? BYTE_MAX : quo);

endmodule

/* rtl/bmpw_dp.sv */
// ----------------------------------------------------------------------------
// bmpw_dp
// Datapath: row/column position, header size arithmetic, three divide
// lanes and the output word register.
// ----------------------------------------------------------------------------
module bmpw_dp import bmpw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  bmpw_cmd_t   cmd,
  output bmpw_sts_t   sts,
  input  logic [16:0] image_width,
  input  logic [16:0] image_height,
  input  logic [31:0] pixel_word,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        image_done
);

  logic [16:0] column_count;
  logic [16:0] row_count;
  logic [31:0] body;
  logic [31:0] total;

  logic [16:0] w;
  logic [16:0] h;
  logic [17:0] row_bytes;
  logic [34:0] body_prod;
  logic [7:0]  lane_res [3];
  logic [7:0]  byte_next;

  assign w = eff_side(image_width);
  assign h = eff_side(image_height);

  // status toward the controller
  assign sts.pad      = w[1:0];
  assign sts.drop     = (row_count >= h);
  assign sts.row_end  = ({1'b0, column_count} + 18'd1 >= {1'b0, w});
  assign sts.img_end  = sts.row_end && ({1'b0, row_count} + 18'd1 >= {1'b0, h});
  assign sts.out_free = !out_valid || out_ready;

  // image position
  always_ff @(posedge clk) begin
    if (rst || cmd.pos_clear) begin
      column_count <= 17'd0;
      row_count    <= 17'd0;
    end else if (cmd.pos_advance) begin
      if (sts.row_end) begin
        column_count <= 17'd0;
        row_count    <= row_count + 17'd1;
      end else begin
        column_count <= column_count + 17'd1;
      end
    end
  end

  // body and file size, one multiply then one add
  assign row_bytes = ({1'b0, w} + {w, 1'b0}) + {16'd0, w[1:0]};
  assign body_prod = 35'(row_bytes) * 35'(h);

  always_ff @(posedge clk) begin
    if (cmd.body_calc) begin
      body <= body_prod[31:0];
    end
    if (cmd.total_calc) begin
      total <= body + 32'(HDR_LEN);
    end
  end

  // unpremultiply lanes: blue, green, red
  for (genvar i = 0; i < 3; i++) begin : g_lane
    bmpw_div u_div (
      .clk      (clk),
      .load     (cmd.pix_load),
      .step     (cmd.div_step),
      .step_idx (cmd.div_idx),
      .chan     (pixel_word[8*i +: 8]),
      .alpha    (pixel_word[31:24]),
      .result   (lane_res[i])
    );
  end

  // byte source select
  always_comb begin
    unique case (cmd.sel)
      SEL_HDR:   byte_next = hdr_byte(cmd.hdr_idx, total, body, w, h);
      SEL_BLUE:  byte_next = lane_res[0];
      SEL_GREEN: byte_next = lane_res[1];
      SEL_RED:   byte_next = lane_res[2];
      SEL_ZERO:  byte_next = 8'd0;
      default:   byte_next = 8'd0;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte    <= byte_next;
      last_of_run <= cmd.last;
      image_done  <= cmd.done;
    end
  end

endmodule

/* rtl/bmpw_ctrl.sv */
// ----------------------------------------------------------------------------
// bmpw_ctrl
// Controller: sequences header emission, divide steps and the pixel bytes
// with row padding.
// ----------------------------------------------------------------------------
module bmpw_ctrl import bmpw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      req_type,
  input  bmpw_sts_t sts,
  output bmpw_cmd_t cmd
);

  state_t     state;
  state_t     state_next;
  logic [5:0] hdr_idx;
  logic [5:0] hdr_idx_next;
  logic [1:0] div_idx;
  logic [1:0] div_idx_next;
  logic [1:0] pad_left;
  logic [1:0] pad_left_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      hdr_idx  <= 6'd0;
      div_idx  <= 2'd0;
      pad_left <= 2'd0;
    end else begin
      state    <= state_next;
      hdr_idx  <= hdr_idx_next;
      div_idx  <= div_idx_next;
      pad_left <= pad_left_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next    = state;
    hdr_idx_next  = hdr_idx;
    div_idx_next  = div_idx;
    pad_left_next = pad_left;
    cmd           = '0;
    cmd.sel       = SEL_ZERO;
    cmd.hdr_idx   = hdr_idx;
    cmd.div_idx   = div_idx;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_START) begin
            cmd.pos_clear = 1'b1;
            state_next    = ST_HDR_MUL;
          end else if (!sts.drop) begin
            cmd.pix_load  = 1'b1;
            div_idx_next  = 2'd0;
            state_next    = ST_DIV;
          end
        end
      end
      ST_HDR_MUL: begin
        cmd.body_calc = 1'b1;
        state_next    = ST_HDR_ADD;
      end
      ST_HDR_ADD: begin
        cmd.total_calc = 1'b1;
        hdr_idx_next   = 6'd0;
        state_next     = ST_HDR_OUT;
      end
      ST_HDR_OUT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_HDR;
          cmd.last = (hdr_idx == HDR_LAST);
          if (hdr_idx == HDR_LAST) begin
            state_next = ST_IDLE;
          end else begin
            hdr_idx_next = hdr_idx + 6'd1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_idx_next = div_idx + 2'd1;
        if (div_idx == 2'd3) begin
          state_next = ST_OUT_B;
        end
      end
      ST_OUT_B: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_BLUE;
          state_next = ST_OUT_G;
        end
      end
      ST_OUT_G: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_GREEN;
          state_next = ST_OUT_R;
        end
      end
      ST_OUT_R: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_RED;
          if (!sts.row_end || sts.pad == 2'd0) begin
            cmd.last        = 1'b1;
            cmd.done        = sts.img_end;
            cmd.pos_advance = 1'b1;
            state_next      = ST_IDLE;
          end else begin
            pad_left_next = sts.pad;
            state_next    = ST_OUT_PAD;
          end
        end
      end
      ST_OUT_PAD: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_ZERO;
          if (pad_left == 2'd1) begin
            cmd.last        = 1'b1;
            cmd.done        = sts.img_end;
            cmd.pos_advance = 1'b1;
            state_next      = ST_IDLE;
          end else begin
            pad_left_next = pad_left - 2'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/bmp24_stream_writer.sv */
// ----------------------------------------------------------------------------
// bmp24_stream_writer
// Premultiplied ARGB8888 pixels in, 24-bit BMP file bytes out.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    req_type, pixel_word
//   out      output     out_valid / out_ready  out_byte, last_of_run, image_done
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// A start word is accepted, then the size arithmetic runs (one multiply,
// one add), then the 54 header bytes are sent. A pixel word is accepted,
// stepped through the two-bit-per-step divide lanes, then sent as 3 to 6
// bytes.
// A pixel past the last row is dropped in its accept cycle.
// Output stalls hold the controller; in_ready is high only between words.
// Reset clears position, state and the output valid flag; sizes reset to 1.
// ----------------------------------------------------------------------------
module bmp24_stream_writer import bmpw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [31:0] pixel_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        image_done,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  logic [16:0] image_width;
  logic [16:0] image_height;
  bmpw_cmd_t   cmd;
  bmpw_sts_t   sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 17'd1;
      image_height <= 17'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  image_width  <= cfg_data;
        CFG_HEIGHT: image_height <= cfg_data;
        default:    image_width  <= image_width;
      endcase
    end
  end

  bmpw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd)
  );

  bmpw_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .image_width  (image_width),
    .image_height (image_height),
    .pixel_word   (pixel_word),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .image_done   (image_done)
  );

  // a word is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("word loaded into occupied output register");

  // image end flag only on the closing word of a run at the last pixel
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.done) |-> (cmd.last && sts.img_end))
    else $error("image_done without last_of_run at image end");

  // divide lanes only step while an item is in flight
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !in_ready)
    else $error("divide step while idle");

  // a start word always leads into header emission
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && req_type == REQ_START) |=> !in_ready)
    else $error("start word did not begin header");

endmodule

/* verif/bmp24_stream_writer_test.sv */
// ----------------------------------------------------------------------------
// bmp24_stream_writer_test
// Self-checking bench for the 24-bit BMP stream writer. A queue of start and
// pixel words feeds a valid/ready driver. Every accepted word is run through
// a local model of the header builder, the unpremultiply and the row padding.
// A monitor compares each output byte and its flags with the oldest expected
// byte. Image sizes change only while the block is idle, and both handshakes
// stall at random.
// ----------------------------------------------------------------------------
module bmp24_stream_writer_test import bmpw_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned MAX_PRINTS = 100;

  typedef struct packed {
    logic        kind;
    logic [31:0] pixel;
  } bmp_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } bmp_byte_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = REQ_START;
  logic [31:0] pixel_word = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        image_done;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_WIDTH;
  logic [16:0] cfg_data = 17'd0;

  // pending words, expected bytes and local copy of the block state
  bmp_req_t    req_backlog[$];
  bmp_byte_t   due_bytes[$];
  logic [16:0] img_w = 17'd1;
  logic [16:0] img_h = 17'd1;
  logic [16:0] col_pos = 17'd0;
  logic [16:0] row_pos = 17'd0;

  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_seen = 0;
  int unsigned cycle_count = 0;

  int unsigned send_gap = 0;
  int unsigned send_quiet = 0;
  int unsigned recv_hold = 0;
  int unsigned recv_quiet = 0;
  bmp_req_t    next_req;
  bmp_byte_t   want;

  bmp24_stream_writer uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .pixel_word  (pixel_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .image_done  (image_done),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // out-of-range sides count as 1 or as the maximum
  function automatic logic [16:0] clamp_side(input logic [16:0] v);
    if (v == 17'd0) return 17'd1;
    if (v > SIDE_MAX) return SIDE_MAX;
    return v;
  endfunction

  // premultiplied channel back to straight color
  function automatic logic [7:0] unpremul(input logic [7:0] c, input logic [7:0] a);
    int unsigned cc;
    int unsigned aa;
    int unsigned q;
    cc = c;
    aa = a;
    q = cc;
    if (aa != 0 && aa != 255) begin
      q = (cc * 255 + aa / 2) / aa;
      if (q > 255) q = 255;
    end
    return 8'(q);
  endfunction

  // expected bytes for one accepted word
  task automatic predict_bmp_bytes(input logic kind, input logic [31:0] px);
    logic [16:0] w;
    logic [16:0] h;
    logic [1:0]  pad;
    logic [63:0] body;
    logic [31:0] f_total;
    logic [31:0] f_body;
    logic [31:0] f_offset;
    logic [31:0] f_info;
    logic [31:0] f_w;
    logic [31:0] f_h;
    logic [7:0]  hdr [0:53];
    logic [7:0]  a;
    logic [7:0]  red;
    logic [7:0]  grn;
    logic [7:0]  blu;
    logic        row_end;
    logic        img_end;
    int          k;
    w = clamp_side(img_w);
    h = clamp_side(img_h);
    pad = w[1:0];
    if (kind == REQ_START) begin
      body = (64'(w) * 64'd3 + 64'(pad)) * 64'(h);
      f_total = 32'(body + 64'd54);
      f_body = 32'(body);
      f_offset = 32'd54;
      f_info = 32'd40;
      f_w = 32'(w);
      f_h = 32'(h);
      for (k = 0; k < 54; k++) hdr[k] = 8'd0;
      // "BM" signature
      hdr[0] = 8'h42;
      hdr[1] = 8'h4D;
      for (k = 0; k < 4; k++) begin
        hdr[2 + k]  = f_total[8*k +: 8];
        hdr[10 + k] = f_offset[8*k +: 8];
        hdr[14 + k] = f_info[8*k +: 8];
        hdr[18 + k] = f_w[8*k +: 8];
        hdr[22 + k] = f_h[8*k +: 8];
        hdr[34 + k] = f_body[8*k +: 8];
      end
      hdr[26] = 8'd1;
      hdr[28] = 8'd24;
      for (k = 0; k < 54; k++) due_bytes.push_back('{hdr[k], k == 53, 1'b0});
      col_pos = 17'd0;
      row_pos = 17'd0;
      return;
    end
    // pixels past the last row vanish
    if (row_pos >= h) return;
    a = px[31:24];
    red = unpremul(px[23:16], a);
    grn = unpremul(px[15:8], a);
    blu = unpremul(px[7:0], a);
    row_end = (32'(col_pos) + 32'd1 >= 32'(w));
    img_end = row_end && (32'(row_pos) + 32'd1 >= 32'(h));
    due_bytes.push_back('{blu, 1'b0, 1'b0});
    due_bytes.push_back('{grn, 1'b0, 1'b0});
    if (!row_end || pad == 2'd0) begin
      due_bytes.push_back('{red, 1'b1, img_end});
    end else begin
      due_bytes.push_back('{red, 1'b0, 1'b0});
      for (k = 0; k < int'(pad); k++) begin
        due_bytes.push_back('{8'd0, k == int'(pad) - 1, (k == int'(pad) - 1) && img_end});
      end
    end
    if (row_end) begin
      col_pos = 17'd0;
      row_pos = row_pos + 17'd1;
    end else begin
      col_pos = col_pos + 17'd1;
    end
  endtask

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // random premultiplied pixel, now and then with channels above alpha
  function automatic logic [31:0] rand_pixel();
    logic [7:0]  a;
    logic [31:0] px;
    case ($urandom_range(0, 9))
      0:       a = 8'd0;
      1:       a = 8'd255;
      2:       a = 8'd1;
      default: a = 8'($urandom_range(0, 255));
    endcase
    px = $urandom();
    if ($urandom_range(0, 3) != 0) begin
      px[23:16] = 8'($urandom_range(0, a));
      px[15:8]  = 8'($urandom_range(0, a));
      px[7:0]   = 8'($urandom_range(0, a));
    end
    px[31:24] = a;
    return px;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < MAX_PRINTS) $display("mismatch at byte %0d: %s", bytes_seen, what);
    mismatches++;
  endtask

  task automatic queue_word(input logic kind, input logic [31:0] px);
    req_backlog.push_back('{kind, px});
    words_queued++;
  endtask

  // every word taken and every byte out, then a settling wait for dropped pixels
  task automatic wait_idle();
    while (words_taken != words_queued || due_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [16:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) img_w = val;
    else img_h = val;
  endtask

  task automatic resize(input logic [16:0] w, input logic [16:0] h);
    wait_idle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  // word driver: predicts on acceptance, then loads the next word after a gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_bmp_bytes(req_type, pixel_word);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          next_req = req_backlog.pop_front();
          req_type <= next_req.kind;
          pixel_word <= next_req.pixel;
          in_valid <= 1'b1;
          if (send_quiet != 0) begin
            send_quiet--;
          end else begin
            send_gap = pick_gap();
            if ($urandom_range(0, 31) == 0) send_quiet = $urandom_range(20, 60);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // byte monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_bytes.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %h", out_byte));
        end else begin
          want = due_bytes.pop_front();
          if (out_byte !== want.data)
            flag_mismatch($sformatf("out_byte %h, want %h", out_byte, want.data));
          if (last_of_run !== want.last)
            flag_mismatch($sformatf("last_of_run %b, want %b", last_of_run, want.last));
          if (image_done !== want.done)
            flag_mismatch($sformatf("image_done %b, want %b", image_done, want.done));
        end
        bytes_seen++;
      end
      if (recv_quiet != 0) begin
        recv_quiet--;
        out_ready <= 1'b1;
      end else if (recv_hold != 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_hold = pick_gap();
        if ($urandom_range(0, 63) == 0) recv_quiet = $urandom_range(30, 120);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bmp24_stream_writer regression: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned sel;
    int unsigned mode;
    longint      n_px;
    longint      cut;
    while (rst) @(posedge clk);

    // reset sizes: pixel before any start, pixel past the end, alpha 0
    queue_word(REQ_PIXEL, 32'h80402010);
    queue_word(REQ_PIXEL, 32'hFFFFFFFF);
    queue_word(REQ_START, 32'h00000000);
    queue_word(REQ_PIXEL, 32'h00FFFFFF);
    queue_word(REQ_PIXEL, 32'h12345678);

    // zero sides read as 1, alpha 1 clamps every channel
    resize(17'd0, 17'd0);
    queue_word(REQ_START, 32'hFFFFFFFF);
    queue_word(REQ_PIXEL, 32'h01FFFFFF);

    // 3x2 image with three pad bytes per row, then one dropped pixel
    resize(17'd3, 17'd2);
    queue_word(REQ_START, 32'h5A5A5A5A);
    queue_word(REQ_PIXEL, 32'hFF123456);
    queue_word(REQ_PIXEL, 32'h7F7F0000);
    queue_word(REQ_PIXEL, 32'h02010203);
    queue_word(REQ_PIXEL, 32'h80FF80FF);
    queue_word(REQ_PIXEL, 32'hFE000000);
    queue_word(REQ_PIXEL, 32'h00000000);
    queue_word(REQ_PIXEL, 32'hC0A0B0C0);

    // oversized width, full height: sizes overflow 32 bits
    resize(17'h1FFFF, 17'd65536);
    queue_word(REQ_START, 32'h00000000);
    queue_word(REQ_PIXEL, 32'h10101010);
    queue_word(REQ_PIXEL, 32'hFFFFFFFF);

    // width lowered in the middle of a row
    resize(17'd5, 17'h1FFFF);
    queue_word(REQ_START, 32'h00000000);
    queue_word(REQ_PIXEL, 32'h40302010);
    queue_word(REQ_PIXEL, 32'h40103020);
    queue_word(REQ_PIXEL, 32'h40201030);
    wait_idle();
    write_reg(CFG_WIDTH, 17'd2);
    queue_word(REQ_PIXEL, 32'h20201020);

    resize(17'd65536, 17'd1);
    queue_word(REQ_START, 32'h00000000);

    // random images: mostly whole, some cut short, some stray pixels
    while (words_queued < 270) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
        resize(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)));
        queue_word(REQ_START, $urandom());
        repeat ($urandom_range(1, 4)) queue_word(REQ_PIXEL, rand_pixel());
      end else begin
        if (sel != 15 || longint'(clamp_side(img_w)) * longint'(clamp_side(img_h)) > 100) begin
          resize(17'(sel < 12 ? $urandom_range(1, 7) : $urandom_range(8, 24)),
                 17'($urandom_range(1, 4)));
        end
        n_px = longint'(clamp_side(img_w)) * longint'(clamp_side(img_h));
        mode = $urandom_range(0, 9);
        if (mode == 8) begin
          repeat ($urandom_range(1, 6)) queue_word(REQ_PIXEL, rand_pixel());
        end else begin
          if (mode == 9) queue_word(REQ_START, $urandom());
          queue_word(REQ_START, $urandom());
          cut = (mode == 7) ? longint'($urandom_range(0, 32'(n_px - 1))) : n_px;
          repeat (cut) queue_word(REQ_PIXEL, rand_pixel());
          if (mode < 3) repeat ($urandom_range(1, 2)) queue_word(REQ_PIXEL, rand_pixel());
        end
      end
    end

    // drain, then a margin for stray bytes
    wait_idle();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("bmp24_stream_writer regression: pass");
    end else begin
      $display("bmp24_stream_writer regression: fail");
    end
    $finish;
  end

endmodule
